@@ rtl/pnpd_pkg.sv @@
package pnpd_pkg;

  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned INDEX_BITS = 24;
  localparam int unsigned CHAN_BITS  = 8;

  localparam logic [7:0] CHAR_LF   = 8'd10;
  localparam logic [7:0] CHAR_HT   = 8'd9;
  localparam logic [7:0] CHAR_VT   = 8'd11;
  localparam logic [7:0] CHAR_FF   = 8'd12;
  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_SP   = 8'd32;
  localparam logic [7:0] CHAR_HASH = 8'd35;
  localparam logic [7:0] CHAR_P    = 8'd80;
  localparam logic [7:0] CHAR_0    = 8'd48;
  localparam logic [7:0] CHAR_1    = 8'd49;
  localparam logic [7:0] CHAR_2    = 8'd50;
  localparam logic [7:0] CHAR_9    = 8'd57;

  localparam logic [CHAN_BITS-1:0] CHAN_FULL = 8'd255;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_BITMAP = 2'd1,
    MODE_GRAY   = 2'd2,
    MODE_COLOUR = 2'd3
  } mode_e;

  // colour phase codes: which channel of a triple a sample is
  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_RED   = 2'd1;
  localparam logic [1:0] PH_GREEN = 2'd2;

  // one sample handed from the parser to the pixel builder
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [VALUE_BITS-1:0] maximum;
    logic [15:0]           width;
    logic [15:0]           height;
    mode_e                 mode;
    logic [1:0]            phase;
    logic [INDEX_BITS-1:0] index;
  } sample_t;

endpackage

@@ rtl/pnpd_front.sv @@
module pnpd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        text_byte_i,
  input  logic              end_of_file_i,
  output logic              sample_push_o,
  output pnpd_pkg::sample_t sample_o
);

  localparam logic [1:0] LP_ORDINARY = 2'd0;
  localparam logic [1:0] LP_MODE     = 2'd1;
  localparam logic [1:0] LP_REST     = 2'd2;

  logic                            line_start_q, line_start_d;
  logic                            skip_q, skip_d;
  logic [1:0]                      lphase_q, lphase_d;
  logic                            mode_seen_q, mode_seen_d;
  pnpd_pkg::mode_e                 mode_q, mode_d;
  logic [1:0]                      hdr_q, hdr_d;
  logic [pnpd_pkg::VALUE_BITS-1:0] width_q, width_d;
  logic [pnpd_pkg::VALUE_BITS-1:0] height_q, height_d;
  logic [pnpd_pkg::VALUE_BITS-1:0] max_q, max_d;
  logic [pnpd_pkg::VALUE_BITS-1:0] acc_q, acc_d;
  logic                            in_tok_q, in_tok_d;
  logic [1:0]                      cphase_q, cphase_d;
  logic [pnpd_pkg::INDEX_BITS-1:0] pix_q, pix_d;

  logic                            is_nl, is_digit, is_space;
  logic                            tok_end;
  logic [pnpd_pkg::VALUE_BITS-1:0] tok_val;
  logic [pnpd_pkg::VALUE_BITS-1:0] acc_base;
  logic [pnpd_pkg::VALUE_BITS+3:0] acc_next;
  logic [pnpd_pkg::VALUE_BITS+3:0] digit_ext;

  assign is_nl    = (text_byte_i == pnpd_pkg::CHAR_LF);
  assign is_digit = (text_byte_i >= pnpd_pkg::CHAR_0) && (text_byte_i <= pnpd_pkg::CHAR_9);
  assign is_space = (text_byte_i == pnpd_pkg::CHAR_SP) || (text_byte_i == pnpd_pkg::CHAR_HT) ||
                    (text_byte_i == pnpd_pkg::CHAR_LF) || (text_byte_i == pnpd_pkg::CHAR_VT) ||
                    (text_byte_i == pnpd_pkg::CHAR_FF) || (text_byte_i == pnpd_pkg::CHAR_CR);

  assign acc_base  = in_tok_q ? acc_q : '0;
  assign digit_ext = {{(pnpd_pkg::VALUE_BITS){1'b0}}, text_byte_i[3:0]};
  // acc*10 + digit
  assign acc_next  = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0} + digit_ext;

  always_comb begin
    line_start_d  = line_start_q;
    skip_d        = skip_q;
    lphase_d      = lphase_q;
    mode_seen_d   = mode_seen_q;
    mode_d        = mode_q;
    hdr_d         = hdr_q;
    width_d       = width_q;
    height_d      = height_q;
    max_d         = max_q;
    acc_d         = acc_q;
    in_tok_d      = in_tok_q;
    cphase_d      = cphase_q;
    pix_d         = pix_q;
    tok_end       = 1'b0;
    sample_push_o = 1'b0;
    sample_o      = '0;

    if (skip_q) begin
      if (is_nl) begin
        skip_d       = 1'b0;
        line_start_d = 1'b1;
      end
    end else if (lphase_q == LP_MODE) begin
      mode_d      = (text_byte_i == pnpd_pkg::CHAR_1) ? pnpd_pkg::MODE_BITMAP :
                    (text_byte_i == pnpd_pkg::CHAR_2) ? pnpd_pkg::MODE_GRAY :
                                                        pnpd_pkg::MODE_COLOUR;
      mode_seen_d = 1'b1;
      if (is_nl) begin
        lphase_d     = LP_ORDINARY;
        line_start_d = 1'b1;
      end else begin
        lphase_d = LP_REST;
      end
    end else if (lphase_q == LP_REST) begin
      if (is_nl) begin
        lphase_d     = LP_ORDINARY;
        line_start_d = 1'b1;
      end
    end else if (line_start_q && text_byte_i == pnpd_pkg::CHAR_HASH) begin
      line_start_d = 1'b0;
      skip_d       = 1'b1;
    end else if (line_start_q && text_byte_i == pnpd_pkg::CHAR_P) begin
      // new image: drop header and pixel progress
      line_start_d = 1'b0;
      lphase_d     = LP_MODE;
      hdr_d        = '0;
      width_d      = '0;
      height_d     = '0;
      max_d        = '0;
      acc_d        = '0;
      in_tok_d     = 1'b0;
      cphase_d     = pnpd_pkg::PH_BLUE;
      pix_d        = '0;
    end else begin
      line_start_d = is_nl;
      if (mode_seen_q) begin
        if (is_digit) begin
          acc_d    = (acc_next[pnpd_pkg::VALUE_BITS+3:pnpd_pkg::VALUE_BITS] != '0) ?
                     '1 : acc_next[pnpd_pkg::VALUE_BITS-1:0];
          in_tok_d = 1'b1;
        end else if (is_space && in_tok_q) begin
          tok_end = 1'b1;
        end
      end
    end

    // end of file flushes a token still open
    if (end_of_file_i && in_tok_d) begin
      tok_end = 1'b1;
    end

    tok_val = acc_d;
    if (tok_end) begin
      in_tok_d = 1'b0;
      acc_d    = '0;
      if (hdr_d == 2'd0) begin
        width_d = tok_val;
        hdr_d   = 2'd1;
      end else if (hdr_d == 2'd1) begin
        height_d = tok_val;
        hdr_d    = 2'd2;
      end else if (hdr_d == 2'd2 && mode_d != pnpd_pkg::MODE_BITMAP) begin
        max_d = tok_val;
        hdr_d = 2'd3;
      end else begin
        sample_push_o    = accept_i;
        sample_o.value   = tok_val;
        sample_o.maximum = max_d;
        sample_o.width   = width_d;
        sample_o.height  = height_d;
        sample_o.mode    = mode_d;
        sample_o.phase   = cphase_d;
        sample_o.index   = pix_d;
        if (mode_d == pnpd_pkg::MODE_COLOUR && cphase_d != pnpd_pkg::PH_GREEN) begin
          cphase_d = cphase_d + 2'd1;
        end else begin
          cphase_d = pnpd_pkg::PH_BLUE;
          pix_d    = pix_d + 1'b1;
        end
      end
    end

    if (end_of_file_i) begin
      line_start_d = 1'b1;
      skip_d       = 1'b0;
      lphase_d     = LP_ORDINARY;
      mode_seen_d  = 1'b0;
      mode_d       = pnpd_pkg::MODE_NONE;
      hdr_d        = '0;
      width_d      = '0;
      height_d     = '0;
      max_d        = '0;
      acc_d        = '0;
      in_tok_d     = 1'b0;
      cphase_d     = pnpd_pkg::PH_BLUE;
      pix_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_start_q <= 1'b1;
      skip_q       <= 1'b0;
      lphase_q     <= LP_ORDINARY;
      mode_seen_q  <= 1'b0;
      mode_q       <= pnpd_pkg::MODE_NONE;
      hdr_q        <= '0;
      width_q      <= '0;
      height_q     <= '0;
      max_q        <= '0;
      acc_q        <= '0;
      in_tok_q     <= 1'b0;
      cphase_q     <= pnpd_pkg::PH_BLUE;
      pix_q        <= '0;
    end else if (accept_i) begin
      line_start_q <= line_start_d;
      skip_q       <= skip_d;
      lphase_q     <= lphase_d;
      mode_seen_q  <= mode_seen_d;
      mode_q       <= mode_d;
      hdr_q        <= hdr_d;
      width_q      <= width_d;
      height_q     <= height_d;
      max_q        <= max_d;
      acc_q        <= acc_d;
      in_tok_q     <= in_tok_d;
      cphase_q     <= cphase_d;
      pix_q        <= pix_d;
    end
  end

endmodule

@@ rtl/pnpd_fifo.sv @@
module pnpd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pnpd_pkg::sample_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output pnpd_pkg::sample_t data_o
);

  localparam int unsigned DEPTH = 4;

  pnpd_pkg::sample_t mem_q [DEPTH];
  logic [1:0]        wr_ptr_q, wr_ptr_d;
  logic [1:0]        rd_ptr_q, rd_ptr_d;
  logic [2:0]        count_q, count_d;

  assign full_o  = (count_q == 3'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + 2'(push_i);
    rd_ptr_d = rd_ptr_q + 2'(pop_i);
    count_d  = count_q + 3'(push_i) - 3'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ rtl/pnpd_back.sv @@
module pnpd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  pnpd_pkg::sample_t q_data_i,
  output logic              q_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic [23:0]       pixel_index_o,
  output logic [15:0]       image_width_o,
  output logic [15:0]       image_height_o,
  output logic              scale_error_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam int unsigned VB = pnpd_pkg::VALUE_BITS;
  localparam int unsigned CB = pnpd_pkg::CHAN_BITS;

  logic [1:0]        state_q, state_d;
  pnpd_pkg::sample_t ent_q;
  logic [VB-1:0]     rem_q, rem_d;
  logic [CB-1:0]     quo_q, quo_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [CB-1:0]     held_blue_q, held_red_q;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        red_q, green_q, blue_q;
  logic [23:0]       index_q;
  logic [15:0]       width_q, height_q;
  logic              err_q;

  logic [VB+CB-1:0]  num;
  logic [VB:0]       trial, diff;
  logic              ge;
  logic              zero_max, emits, out_write, err_now;

  // v*255 as (v << 8) - v
  assign num   = {ent_q.value, {CB{1'b0}}} - {{CB{1'b0}}, ent_q.value};
  assign trial = {rem_q, quo_q[CB-1]};
  assign ge    = trial >= {1'b0, ent_q.maximum};
  assign diff  = trial - {1'b0, ent_q.maximum};

  assign zero_max  = (ent_q.maximum == '0);
  assign emits     = (ent_q.mode != pnpd_pkg::MODE_COLOUR) || (ent_q.phase == pnpd_pkg::PH_GREEN);
  assign out_write = (state_q == ST_FIN) && emits && (!out_valid_q || pop_i);
  assign err_now   = (ent_q.mode != pnpd_pkg::MODE_BITMAP) && zero_max;
  assign q_pop_o   = (state_q == ST_IDLE) && !q_empty_i;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (ent_q.mode == pnpd_pkg::MODE_BITMAP) begin
          quo_d   = (ent_q.value == '0) ? pnpd_pkg::CHAN_FULL : '0;
          state_d = ST_FIN;
        end else if (zero_max || ent_q.value >= ent_q.maximum) begin
          quo_d   = pnpd_pkg::CHAN_FULL;
          state_d = ST_FIN;
        end else begin
          // quotient fits in 8 bits since v < max
          rem_d   = num[VB+CB-1:CB];
          quo_d   = num[CB-1:0];
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = ge ? diff[VB-1:0] : trial[VB-1:0];
        quo_d = {quo_q[CB-2:0], ge};
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'(CB - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!emits || out_write) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_write) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    if (q_pop_o) begin
      ent_q <= q_data_i;
    end
    if (state_q == ST_FIN && !emits) begin
      if (ent_q.phase == pnpd_pkg::PH_BLUE) begin
        held_blue_q <= quo_q;
      end else begin
        held_red_q <= quo_q;
      end
    end
    if (out_write) begin
      if (ent_q.mode == pnpd_pkg::MODE_COLOUR) begin
        red_q  <= held_red_q;
        blue_q <= held_blue_q;
      end else begin
        red_q  <= quo_q;
        blue_q <= quo_q;
      end
      green_q  <= quo_q;
      index_q  <= ent_q.index;
      width_q  <= ent_q.width;
      height_q <= ent_q.height;
      err_q    <= err_now;
    end
  end

  assign empty_o        = !out_valid_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign pixel_index_o  = index_q;
  assign image_width_o  = width_q;
  assign image_height_o = height_q;
  assign scale_error_o  = err_q;

endmodule

@@ rtl/plain_netpbm_pixel_decoder_top.sv @@
// Plain (ASCII) PBM/PGM/PPM pixel decoder. File text enters one byte per transfer on the
// push side; decoded pixels leave on the pop side, one per transfer, in file order. The
// parser takes a byte every cycle while its four-entry sample queue has room; full rises
// only when the pixel builder falls behind. The builder needs no division for a bitmap,
// a zero maximum or a sample at or above the maximum, and otherwise sends v*255/max
// through its 8-step restoring divider, which sets the sustained rate for gray and
// colour images. Mark the last byte of a file with end_of_file_i: it flushes an
// open token and returns the decoder to its reset state. Width, height and the maximum
// saturate at 65535; pixel_index_o counts from zero and restarts at every 'P' line.
module plain_netpbm_pixel_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_file_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [23:0] pixel_index_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic        scale_error_o
);

  logic              accept;
  logic              q_push, q_full, q_pop, q_empty;
  pnpd_pkg::sample_t q_wdata, q_rdata;

  assign full   = q_full;
  assign accept = push && !q_full;

  pnpd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (text_byte_i),
    .end_of_file_i (end_of_file_i),
    .sample_push_o (q_push),
    .sample_o      (q_wdata)
  );

  pnpd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  pnpd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (q_rdata),
    .q_pop_o        (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .pixel_index_o  (pixel_index_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .scale_error_o  (scale_error_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("sample queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("sample queue read while empty");

  a_err_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && scale_error_o) |->
      (red_o == 8'd255 && green_o == 8'd255 && blue_o == 8'd255))
    else $error("scale error pixel not forced to full scale");

endmodule

@@ tb/sv/plain_netpbm_pixel_decoder_top_test.sv @@
module plain_netpbm_pixel_decoder_top_test;
  import pnpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_BYTES = 1050;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TOKEN_MAX    = (1 << VALUE_BITS) - 1;

  typedef enum logic [1:0] {
    LINE_PLAIN,
    LINE_MODE_DIGIT,
    LINE_MODE_REST
  } line_e;

  typedef struct packed {
    logic [7:0]            r;
    logic [7:0]            g;
    logic [7:0]            b;
    logic [INDEX_BITS-1:0] idx;
    logic [15:0]           w;
    logic [15:0]           h;
    logic                  err;
  } pixel_t;

  typedef struct packed {
    logic [7:0] text;
    logic       eof;
    logic       typed;
    pixel_t     px;
  } row_t;

  localparam pixel_t NO_PIXEL = '0;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  text_byte_i;
  logic        end_of_file_i;
  logic        empty;
  logic        pop;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [23:0] pixel_index_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;
  logic        scale_error_o;

  plain_netpbm_pixel_decoder_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .text_byte_i   (text_byte_i),
    .end_of_file_i (end_of_file_i),
    .empty         (empty),
    .pop           (pop),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .pixel_index_o (pixel_index_o),
    .image_width_o (image_width_o),
    .image_height_o(image_height_o),
    .scale_error_o (scale_error_o)
  );

  always #1 clk_i = ~clk_i;

  // decoder state mirror
  bit                    at_start;
  bit                    in_comment;
  line_e                 line_st;
  bit                    mode_seen;
  mode_e                 cur_mode;
  logic [1:0]            hdr_count;
  logic [15:0]           width_v;
  logic [15:0]           height_v;
  logic [15:0]           max_v;
  logic [15:0]           acc_v;
  bit                    tok_open;
  logic [1:0]            phase;
  logic [7:0]            held_b;
  logic [7:0]            held_r;
  logic [INDEX_BITS-1:0] pix_count;

  pixel_t      pixel_q[$];
  row_t        directed_q[$];
  logic [7:0]  text_q[$];
  int unsigned calm_left[2];
  int unsigned bytes_sent;
  int unsigned pixels_seen;
  int unsigned fail_count;
  int unsigned stall_cycles;
  bit          hold_active;
  bit          hold_done;

  function automatic void clear_image();
    hdr_count = 2'd0;
    width_v   = '0;
    height_v  = '0;
    max_v     = '0;
    acc_v     = '0;
    tok_open  = 1'b0;
    phase     = PH_BLUE;
    held_b    = '0;
    held_r    = '0;
    pix_count = '0;
  endfunction

  function automatic void reset_decoder();
    at_start   = 1'b1;
    in_comment = 1'b0;
    line_st    = LINE_PLAIN;
    mode_seen  = 1'b0;
    cur_mode   = MODE_NONE;
    clear_image();
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CHAR_SP || c == CHAR_HT || c == CHAR_LF || c == CHAR_VT ||
           c == CHAR_FF || c == CHAR_CR;
  endfunction

  function automatic logic [7:0] scale_sample(input logic [15:0] v);
    int unsigned vv;
    int unsigned mm;
    int unsigned q;
    vv = 32'(v);
    mm = 32'(max_v);
    if (mm == 0) return CHAN_FULL;
    q = (vv * 255) / mm;
    return (q > 255) ? CHAN_FULL : q[7:0];
  endfunction

  function automatic pixel_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    pixel_t px;
    px.r   = r;
    px.g   = g;
    px.b   = b;
    px.idx = pix_count;
    px.w   = width_v;
    px.h   = height_v;
    px.err = (cur_mode != MODE_BITMAP) && (max_v == 0);
    pix_count = pix_count + 1'b1;
    return px;
  endfunction

  // a token ends: header field, bitmap/gray pixel, or one channel of a triple
  function automatic bit close_token(output pixel_t px);
    logic [15:0] v;
    logic [7:0]  c;
    bit          made;
    v        = acc_v;
    tok_open = 1'b0;
    acc_v    = '0;
    px       = NO_PIXEL;
    made     = 1'b0;
    if (hdr_count == 2'd0) begin
      width_v   = v;
      hdr_count = 2'd1;
    end else if (hdr_count == 2'd1) begin
      height_v  = v;
      hdr_count = 2'd2;
    end else if (hdr_count == 2'd2 && cur_mode != MODE_BITMAP) begin
      max_v     = v;
      hdr_count = 2'd3;
    end else if (cur_mode == MODE_BITMAP) begin
      c    = (v == 0) ? CHAN_FULL : 8'd0;
      px   = make_pixel(c, c, c);
      made = 1'b1;
    end else begin
      c = scale_sample(v);
      if (cur_mode == MODE_GRAY) begin
        px   = make_pixel(c, c, c);
        made = 1'b1;
      end else if (phase == PH_BLUE) begin
        held_b = c;
        phase  = PH_RED;
      end else if (phase == PH_RED) begin
        held_r = c;
        phase  = PH_GREEN;
      end else begin
        phase = PH_BLUE;
        px    = make_pixel(held_r, c, held_b);
        made  = 1'b1;
      end
    end
    return made;
  endfunction

  function automatic bit decode_byte(input logic [7:0] c, input logic eof, output pixel_t px);
    bit          made;
    bit          nl;
    int unsigned a;
    made = 1'b0;
    nl   = (c == CHAR_LF);
    px   = NO_PIXEL;
    if (in_comment) begin
      if (nl) begin
        in_comment = 1'b0;
        at_start   = 1'b1;
      end
    end else if (line_st == LINE_MODE_DIGIT) begin
      cur_mode  = (c == CHAR_1) ? MODE_BITMAP : (c == CHAR_2) ? MODE_GRAY : MODE_COLOUR;
      mode_seen = 1'b1;
      if (nl) begin
        line_st  = LINE_PLAIN;
        at_start = 1'b1;
      end else begin
        line_st = LINE_MODE_REST;
      end
    end else if (line_st == LINE_MODE_REST) begin
      if (nl) begin
        line_st  = LINE_PLAIN;
        at_start = 1'b1;
      end
    end else if (at_start && c == CHAR_HASH) begin
      at_start   = 1'b0;
      in_comment = 1'b1;
    end else if (at_start && c == CHAR_P) begin
      at_start = 1'b0;
      line_st  = LINE_MODE_DIGIT;
      clear_image();
    end else begin
      at_start = nl;
      if (mode_seen) begin
        if (c >= CHAR_0 && c <= CHAR_9) begin
          a        = tok_open ? 32'(acc_v) : 0;
          a        = a * 10 + 32'(c - CHAR_0);
          acc_v    = (a > TOKEN_MAX) ? TOKEN_MAX[15:0] : a[15:0];
          tok_open = 1'b1;
        end else if (is_blank(c) && tok_open) begin
          made = close_token(px);
        end
      end
    end
    if (eof) begin
      if (tok_open && !made) made = close_token(px);
      reset_decoder();
    end
    return made;
  endfunction

  // side 0 is the sender, side 1 the receiver; now and then a stretch with no gaps
  function automatic int unsigned draw_gap(input int side);
    if (calm_left[side] != 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left[side] = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eof, input logic typed,
                           input pixel_t typed_px);
    int unsigned gap;
    pixel_t      px;
    bit          made;
    gap = hold_active ? 0 : draw_gap(0);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    text_byte_i   <= c;
    end_of_file_i <= eof;
    do @(posedge clk_i); while (full);
    bytes_sent++;
    made = decode_byte(c, eof, px);
    if (typed) pixel_q.push_back(typed_px);
    else if (made) pixel_q.push_back(px);
  endtask

  task automatic add_row(input logic [7:0] c, input logic eof, input logic typed,
                         input pixel_t px);
    row_t r;
    r.text  = c;
    r.eof   = eof;
    r.typed = typed;
    r.px    = px;
    directed_q.push_back(r);
  endtask

  function automatic pixel_t pix(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b, input int unsigned idx,
                                 input int unsigned w, input int unsigned h,
                                 input logic err);
    pixel_t px;
    px.r   = r;
    px.g   = g;
    px.b   = b;
    px.idx = INDEX_BITS'(idx);
    px.w   = 16'(w);
    px.h   = 16'(h);
    px.err = err;
    return px;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 9))
      5:       return CHAR_HT;
      6:       return CHAR_LF;
      7:       return CHAR_VT;
      8:       return CHAR_FF;
      9:       return CHAR_CR;
      default: return CHAR_SP;
    endcase
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    return (c >= CHAR_0 && c <= CHAR_9) ? "x" : c;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return (c == CHAR_LF) ? CHAR_SP : c;
  endfunction

  task automatic put_comment();
    text_q.push_back(CHAR_HASH);
    repeat ($urandom_range(0, 8)) text_q.push_back(text_char());
    text_q.push_back(CHAR_LF);
  endtask

  task automatic put_blank();
    repeat ($urandom_range(1, 2)) text_q.push_back(blank_char());
    if (text_q[$] == CHAR_LF && $urandom_range(0, 5) == 0) put_comment();
  endtask

  // decimal digits, sometimes with leading zeros or an ignored byte between digits
  task automatic put_num(input int unsigned v);
    logic [7:0]  dig[$];
    int unsigned x;
    x = v;
    do begin
      dig.push_front(CHAR_0 + 8'(x % 10));
      x = x / 10;
    end while (x != 0);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) dig.push_front(CHAR_0);
    foreach (dig[i]) begin
      if (i != 0 && $urandom_range(0, 19) == 0) text_q.push_back(junk_char());
      text_q.push_back(dig[i]);
    end
  endtask

  function automatic int unsigned draw_dim();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return TOKEN_MAX;
      2:       return $urandom_range(TOKEN_MAX + 1, 999999);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic int unsigned draw_max();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return 255;
      3:       return TOKEN_MAX;
      4:       return $urandom_range(TOKEN_MAX + 1, 999999);
      5:       return $urandom_range(2, 1000);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  function automatic int unsigned draw_sample(input mode_e m, input int unsigned mx);
    if (m == MODE_BITMAP) begin
      case ($urandom_range(0, 3))
        0:       return 0;
        1:       return 1;
        2:       return $urandom_range(0, 999);
        default: return $urandom_range(0, 1);
      endcase
    end
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return mx;
      2:       return $urandom_range(TOKEN_MAX, 999999);
      3:       return $urandom_range(0, 2 * mx + 1);
      default: return $urandom_range(0, mx);
    endcase
  endfunction

  task automatic random_file();
    logic [7:0]  digit;
    mode_e       m;
    int unsigned n;
    int unsigned mx;
    int unsigned images;
    text_q.delete();
    // pure noise with end_of_file scattered through it
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(5, 40);
      for (int unsigned i = 0; i < n; i++)
        send_byte(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 11) == 0),
                  1'b0, NO_PIXEL);
      return;
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      text_q.push_back(CHAR_LF);
    end
    images = ($urandom_range(0, 5) == 0) ? 2 : 1;
    for (int unsigned img = 0; img < images; img++) begin
      if (text_q.size() != 0 && text_q[$] != CHAR_LF) text_q.push_back(CHAR_LF);
      case ($urandom_range(0, 7))
        0, 1:    digit = CHAR_1;
        2, 3:    digit = CHAR_2;
        4:       digit = CHAR_0 + 8'd3;
        5:       digit = CHAR_0 + 8'd6;
        6:       digit = 8'($urandom_range(0, 255));
        default: digit = CHAR_LF;
      endcase
      m = (digit == CHAR_1) ? MODE_BITMAP : (digit == CHAR_2) ? MODE_GRAY : MODE_COLOUR;
      text_q.push_back(CHAR_P);
      text_q.push_back(digit);
      if (digit != CHAR_LF) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 4)) text_q.push_back(text_char());
        text_q.push_back(CHAR_LF);
      end
      if ($urandom_range(0, 4) == 0) put_comment();
      put_num(draw_dim());
      put_blank();
      put_num(draw_dim());
      put_blank();
      mx = 1;
      if (m != MODE_BITMAP) begin
        mx = draw_max();
        put_num(mx);
        put_blank();
        if (mx > TOKEN_MAX) mx = TOKEN_MAX;
      end
      n = $urandom_range(1, 24);
      for (int unsigned i = 0; i < n; i++) begin
        put_num(draw_sample(m, mx));
        // the file may end right on a digit, leaving the token to the end marker
        if (!(img == images - 1 && i == n - 1 && $urandom_range(0, 1) == 0)) put_blank();
      end
    end
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1, 1'b0, NO_PIXEL);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : drain
    int unsigned gap;
    pixel_t      got_px;
    pixel_t      want;
    wait (rst_ni === 1'b1);
    forever begin
      if (!hold_done && pixels_seen >= 40) begin
        // long hold-off so the block backs up and stalls its input
        hold_done   = 1'b1;
        hold_active = 1'b1;
        gap         = HOLD_CYCLES;
      end else begin
        gap = draw_gap(1);
      end
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      hold_active = 1'b0;
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got_px.r   = red_o;
      got_px.g   = green_o;
      got_px.b   = blue_o;
      got_px.idx = pixel_index_o;
      got_px.w   = image_width_o;
      got_px.h   = image_height_o;
      got_px.err = scale_error_o;
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected pixel: idx=%0d r=%0d g=%0d b=%0d", got_px.idx, got_px.r,
                   got_px.g, got_px.b);
        fail_count++;
      end else begin
        want = pixel_q.pop_front();
        if (got_px !== want) begin
          if (fail_count < 10) begin
            $display("pixel mismatch: exp r=%0d g=%0d b=%0d idx=%0d w=%0d h=%0d err=%0d",
                     want.r, want.g, want.b, want.idx, want.w, want.h, want.err);
            $display("                got r=%0d g=%0d b=%0d idx=%0d w=%0d h=%0d err=%0d",
                     got_px.r, got_px.g, got_px.b, got_px.idx, got_px.w, got_px.h,
                     got_px.err);
          end
          fail_count++;
        end
      end
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    text_byte_i   = '0;
    end_of_file_i = 1'b0;
    reset_decoder();

    // comment and stray text before any mode line, then a 2x1 bitmap
    add_row(CHAR_HASH, 1'b0, 1'b0, NO_PIXEL);
    add_row(8'h00,     1'b0, 1'b0, NO_PIXEL);
    add_row(8'hFF,     1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_LF,   1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_P,    1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_1,    1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_LF,   1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_2,    1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_SP,   1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_1,    1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_SP,   1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_0,    1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_SP,   1'b0, 1'b1, pix(8'd255, 8'd255, 8'd255, 0, 2, 1, 1'b0));
    add_row("7",       1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_LF,   1'b0, 1'b1, pix(8'd0, 8'd0, 8'd0, 1, 2, 1, 1'b0));
    // gray image with a zero maximum, last token flushed by the end marker
    add_row(CHAR_P,    1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_2,    1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_LF,   1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_1,    1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_SP,   1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_1,    1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_SP,   1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_0,    1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_SP,   1'b0, 1'b0, NO_PIXEL);
    add_row(CHAR_9,    1'b1, 1'b1, pix(8'd255, 8'd255, 8'd255, 0, 1, 1, 1'b1));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_q[i])
      send_byte(directed_q[i].text, directed_q[i].eof, directed_q[i].typed,
                directed_q[i].px);
    while (bytes_sent < directed_q.size() + RANDOM_BYTES) random_file();
    push <= 1'b0;

    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ plain_netpbm_pixel_decoder_top.f @@
rtl/pnpd_pkg.sv
rtl/pnpd_front.sv
rtl/pnpd_fifo.sv
rtl/pnpd_back.sv
rtl/plain_netpbm_pixel_decoder_top.sv
tb/sv/plain_netpbm_pixel_decoder_top_test.sv
